// ===== hdl/pps_pkg.sv =====
// Shared constants of the PPS clock servo: status codes, register indexes, divider sizing.
package pps_pkg;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_APPLIED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TIME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RESET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDEND_BASE  = 3'd5;

    localparam logic        RST_CLOCK_KIND   = 1'b0;
    localparam logic [19:0] RST_OFFSET_RESET = 20'd50000;
    localparam logic [9:0]  RST_PROP_GAIN    = 10'd171;
    localparam logic [9:0]  RST_INT_GAIN     = 10'd57;
    localparam logic [23:0] RST_DRIFT_LIMIT  = 24'd12800000;
    localparam logic [31:0] RST_ADDEND_BASE  = 32'd3067833783;

    // addend_base * |drift| + half scale, divided by 2^8 * 1e9
    localparam int NUM_W    = 57;
    localparam int QUO_W    = 19;
    localparam int REM_W    = NUM_W - QUO_W;
    localparam int DIV_CNT_W = 5;
    localparam logic [REM_W-1:0] DRIFT_SCALE = 38'd256000000000;
    localparam logic [NUM_W-1:0] DRIFT_HALF  = 57'd128000000000;

endpackage

// ===== hdl/pps_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module pps_mul #(
    parameter int A_W = 20,
    parameter int B_W = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_prod,
    output logic               o_done
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_acc;
    logic [A_W+B_W-1:0] n_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_done;
    logic               n_done;
    logic [A_W:0]       w_sum;

    always_comb begin
        w_sum  = {1'b0, r_acc[A_W+B_W-1:B_W]} + (r_acc[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = {{A_W{1'b0}}, i_b};
            n_cnt = CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            n_acc  = {w_sum, r_acc[B_W-1:1]};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_start) begin
            r_a <= i_a;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== hdl/pps_div.sv =====
// Restoring divider by the drift scale constant, one quotient bit per cycle.
module pps_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pps_pkg::NUM_W-1:0] i_num,
    output logic [pps_pkg::QUO_W-1:0] o_quo,
    output logic                      o_done
);

    logic [pps_pkg::REM_W-1:0]     r_rem;
    logic [pps_pkg::REM_W-1:0]     n_rem;
    logic [pps_pkg::QUO_W-1:0]     r_quo;
    logic [pps_pkg::QUO_W-1:0]     n_quo;
    logic [pps_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pps_pkg::DIV_CNT_W-1:0] n_cnt;
    logic                          r_done;
    logic                          n_done;
    logic [pps_pkg::REM_W:0]       w_trial;
    logic [pps_pkg::REM_W:0]       w_diff;
    logic                          w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[pps_pkg::QUO_W-1]};
        w_ge    = w_trial >= {1'b0, pps_pkg::DRIFT_SCALE};
        w_diff  = w_trial - {1'b0, pps_pkg::DRIFT_SCALE};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem = i_num[pps_pkg::NUM_W-1:pps_pkg::QUO_W];
            n_quo = i_num[pps_pkg::QUO_W-1:0];
            n_cnt = pps_pkg::DIV_CNT_W'(pps_pkg::QUO_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? w_diff[pps_pkg::REM_W-1:0] : w_trial[pps_pkg::REM_W-1:0];
            n_quo  = {r_quo[pps_pkg::QUO_W-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == pps_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== hdl/pps_clock_pi_servo.sv =====
// PPS clock servo top level: sequencer, servo state, config registers, result register.
//
// One input transaction is one pulse event: reference time and latched local time.
// One output transaction follows for every input: status, addend, drift, rate
// adjustment, measured offset, phase step, phase offset to write, pulse time.
// A latched time of zero gives status "no time". Otherwise the item runs through
// two 10-bit serial gain multipliers, a 24-bit serial addend multiplier and a
// 19-step serial divider by 2^8 * 1e9. The serial multiply and divide set the time
// per item. One item is worked at a time; o_in_stall is high from acceptance until
// its result is loaded into the output register. A result waiting under i_out_stall
// holds its payload; the next input may be accepted meanwhile, and its result waits
// until the register is free. Configuration is written through i_cfg_we /
// i_cfg_idx / i_cfg_data; the user must write it only while idle, and the block
// itself does not enforce that. Synchronous reset restores register defaults, arms
// the seed flag and clears drift and accumulated offset; the block is ready as soon
// as reset is released.
module pps_clock_pi_servo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [62:0]                   i_reference_ns,
    input  logic [62:0]                   i_latched_ns,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pps_pkg::STATUS_W-1:0]  o_status,
    output logic [31:0]                   o_new_addend,
    output logic signed [24:0]            o_drift_q8,
    output logic signed [32:0]            o_rate_adjust,
    output logic signed [63:0]            o_measured_offset,
    output logic signed [63:0]            o_phase_step,
    output logic signed [63:0]            o_phase_offset,
    output logic [62:0]                   o_pulse_time
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OFFS  = 7'b0000010,
        S_GAIN  = 7'b0000100,
        S_CLAMP = 7'b0001000,
        S_BMUL  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic        r_clock_kind;
    logic [19:0] r_offset_reset_ns;
    logic [9:0]  r_prop_gain_q8;
    logic [9:0]  r_int_gain_q8;
    logic [23:0] r_drift_limit_q8;
    logic [31:0] r_addend_base;

    logic              r_await;
    logic signed [24:0] r_drift_est;
    logic [63:0]       r_acc_off;

    logic [62:0]               r_ref;
    logic [62:0]               r_lat;
    logic [63:0]               r_offset;
    logic                      r_neg;
    logic                      r_slam;
    logic [pps_pkg::STATUS_W-1:0] r_status;
    logic [31:0]               r_dpre;
    logic [63:0]               r_step;
    logic [24:0]               r_drift;
    logic [pps_pkg::QUO_W-1:0] r_aoff;

    logic        r_out_valid;
    logic [pps_pkg::STATUS_W-1:0] r_o_status;
    logic [31:0] r_o_addend;
    logic [24:0] r_o_drift;
    logic [63:0] r_o_offset;
    logic [63:0] r_o_step;
    logic [63:0] r_o_phase;
    logic [62:0] r_o_pulse;

    logic [63:0] w_diff;
    logic        w_neg;
    logic        w_ult;
    logic [63:0] w_omag;
    logic        w_slam;
    logic [pps_pkg::STATUS_W-1:0] w_status;

    logic        w_gain_start;
    logic [29:0] w_ip;
    logic [29:0] w_pp;
    logic        w_ip_done;
    logic        w_pp_done;
    logic [31:0] w_ipx;
    logic [31:0] w_track;
    logic [31:0] w_seed;
    logic [31:0] w_dpre;
    logic [30:0] w_pround;
    logic [63:0] w_smag;
    logic [63:0] w_step;

    logic        w_dneg;
    logic [31:0] w_dabs;
    logic [23:0] w_dm;
    logic [24:0] w_drift;

    logic        w_bmul_start;
    logic [55:0] w_bprod;
    logic        w_bmul_done;
    logic [pps_pkg::NUM_W-1:0] w_num;
    logic [pps_pkg::QUO_W-1:0] w_quo;
    logic        w_div_done;

    logic        w_load;
    logic        w_applied;
    logic        w_dpos;
    logic [31:0] w_aoff32;
    logic [31:0] w_addend;
    logic [63:0] w_acc_next;

    // offset and its magnitude
    always_comb begin
        w_diff = {1'b0, r_ref} - {1'b0, r_lat};
        w_neg  = w_diff[63];
        w_ult  = r_ref < r_lat;
        w_omag = w_neg ? (64'd0 - w_diff) : w_diff;
        w_slam = w_omag > {44'd0, r_offset_reset_ns};
        if (r_lat == 63'd0) begin
            w_status = pps_pkg::ST_NO_TIME;
        end else if (w_neg != w_ult) begin
            w_status = pps_pkg::ST_UNDERFLOW;
        end else begin
            w_status = pps_pkg::ST_APPLIED;
        end
    end

    assign w_gain_start = (r_state == S_OFFS) && (w_status == pps_pkg::ST_APPLIED);

    pps_mul #(.A_W(20), .B_W(10)) u_int_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gain_start),
        .i_a     (w_omag[19:0]),
        .i_b     (r_int_gain_q8),
        .o_prod  (w_ip),
        .o_done  (w_ip_done)
    );

    pps_mul #(.A_W(20), .B_W(10)) u_prop_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gain_start),
        .i_a     (w_omag[19:0]),
        .i_b     (r_prop_gain_q8),
        .o_prod  (w_pp),
        .o_done  (w_pp_done)
    );

    // drift before clamp and phase step
    always_comb begin
        w_ipx    = {2'b00, w_ip};
        w_track  = {{7{r_drift_est[24]}}, r_drift_est} + (r_neg ? (32'd0 - w_ipx) : w_ipx);
        w_seed   = {{3{r_offset[20]}}, r_offset[20:0], 8'd0};
        w_pround = {1'b0, w_pp} + 31'd128;
        w_smag   = {41'd0, w_pround[30:8]};
        if (r_slam) begin
            w_dpre = 32'd0;
            w_step = r_offset;
        end else if (r_await) begin
            w_dpre = w_seed;
            w_step = r_offset;
        end else begin
            w_dpre = w_track;
            w_step = r_neg ? (64'd0 - w_smag) : w_smag;
        end
    end

    // clamp to the drift limit
    always_comb begin
        w_dneg  = r_dpre[31];
        w_dabs  = w_dneg ? (32'd0 - r_dpre) : r_dpre;
        w_dm    = (w_dabs > {8'd0, r_drift_limit_q8}) ? r_drift_limit_q8 : w_dabs[23:0];
        w_drift = w_dneg ? (25'd0 - {1'b0, w_dm}) : {1'b0, w_dm};
    end

    assign w_bmul_start = (r_state == S_CLAMP);

    pps_mul #(.A_W(32), .B_W(24)) u_addend_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bmul_start),
        .i_a     (r_addend_base),
        .i_b     (w_dm),
        .o_prod  (w_bprod),
        .o_done  (w_bmul_done)
    );

    assign w_num = {1'b0, w_bprod} + pps_pkg::DRIFT_HALF;

    pps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_BMUL) && w_bmul_done),
        .i_num   (w_num),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // result assembly
    always_comb begin
        w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
        w_applied  = (r_status == pps_pkg::ST_APPLIED);
        w_dpos     = !r_drift[24] && (r_drift != 25'd0);
        w_aoff32   = {{(32-pps_pkg::QUO_W){1'b0}}, r_aoff};
        w_addend   = w_dpos ? (r_addend_base + w_aoff32) : (r_addend_base - w_aoff32);
        w_acc_next = r_acc_off + r_step;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_OFFS;
                end
            end
            S_OFFS: begin
                n_state = (w_status == pps_pkg::ST_APPLIED) ? S_GAIN : S_DONE;
            end
            S_GAIN: begin
                if (w_ip_done && w_pp_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = S_BMUL;
            end
            S_BMUL: begin
                if (w_bmul_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_clock_kind      <= pps_pkg::RST_CLOCK_KIND;
            r_offset_reset_ns <= pps_pkg::RST_OFFSET_RESET;
            r_prop_gain_q8    <= pps_pkg::RST_PROP_GAIN;
            r_int_gain_q8     <= pps_pkg::RST_INT_GAIN;
            r_drift_limit_q8  <= pps_pkg::RST_DRIFT_LIMIT;
            r_addend_base     <= pps_pkg::RST_ADDEND_BASE;
            r_await           <= 1'b1;
            r_drift_est       <= '0;
            r_acc_off         <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pps_pkg::CFG_CLOCK_KIND:   r_clock_kind      <= i_cfg_data[0];
                    pps_pkg::CFG_OFFSET_RESET: r_offset_reset_ns <= i_cfg_data[19:0];
                    pps_pkg::CFG_PROP_GAIN:    r_prop_gain_q8    <= i_cfg_data[9:0];
                    pps_pkg::CFG_INT_GAIN:     r_int_gain_q8     <= i_cfg_data[9:0];
                    pps_pkg::CFG_DRIFT_LIMIT:  r_drift_limit_q8  <= i_cfg_data[23:0];
                    pps_pkg::CFG_ADDEND_BASE:  r_addend_base     <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (w_load && w_applied) begin
                r_await     <= r_slam;
                r_drift_est <= r_drift;
                r_acc_off   <= w_acc_next;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_ref <= i_reference_ns;
            r_lat <= i_latched_ns;
        end
        if (r_state == S_OFFS) begin
            r_offset <= w_diff;
            r_neg    <= w_neg;
            r_slam   <= w_slam;
            r_status <= w_status;
        end
        if ((r_state == S_GAIN) && w_ip_done) begin
            r_dpre <= w_dpre;
            r_step <= w_step;
        end
        if (r_state == S_CLAMP) begin
            r_drift <= w_drift;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_aoff <= w_quo;
        end
        if (w_load) begin
            r_o_status <= r_status;
            if (w_applied) begin
                r_o_addend <= w_addend;
                r_o_drift  <= r_drift;
                r_o_offset <= r_offset;
                r_o_step   <= r_step;
                r_o_phase  <= r_clock_kind ? r_step : w_acc_next;
                r_o_pulse  <= r_lat;
            end else begin
                r_o_addend <= '0;
                r_o_drift  <= '0;
                r_o_offset <= '0;
                r_o_step   <= '0;
                r_o_phase  <= '0;
                r_o_pulse  <= '0;
            end
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_new_addend      = r_o_addend;
    assign o_drift_q8        = r_o_drift;
    assign o_rate_adjust     = {r_o_drift, 8'd0};
    assign o_measured_offset = r_o_offset;
    assign o_phase_step      = r_o_step;
    assign o_phase_offset    = r_o_phase;
    assign o_pulse_time      = r_o_pulse;

endmodule

// ===== hdl/pps_chk.sv =====
// Port-level checker for the PPS clock servo, bound to the top level.
module pps_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pps_pkg::STATUS_W-1:0]  o_status,
    input logic [31:0]                   o_new_addend,
    input logic signed [24:0]            o_drift_q8,
    input logic signed [32:0]            o_rate_adjust,
    input logic signed [63:0]            o_phase_step,
    input logic signed [63:0]            o_phase_offset,
    input logic [62:0]                   o_pulse_time
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_phase_offset)))
        else $error("stalled result dropped or changed");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    a_rate_matches_drift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rate_adjust == {o_drift_q8, 8'd0}))
        else $error("rate adjustment differs from drift");

    a_skip_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pps_pkg::ST_APPLIED) |->
        (o_phase_step == 64'd0 && o_phase_offset == 64'd0 && o_pulse_time == 63'd0
         && o_new_addend == 32'd0))
        else $error("skipped transaction carries data");

endmodule

bind pps_clock_pi_servo pps_chk u_pps_chk (.*);
